// ===== rtl/core/vrp_pkg.sv =====
package vrp_pkg;

  localparam int ANGLE_BITS       = 12;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int COORD_WIDTH      = 16;

  localparam int SIZE_W    = 16;
  localparam int CFG_W     = (COORD_WIDTH > SIZE_W) ? COORD_WIDTH : SIZE_W;
  localparam int CFG_IDX_W = 3;

  localparam int TRIG_FRAC = 14;
  localparam int TRIG_W    = TRIG_FRAC + 2;
  localparam int TAB_W     = TRIG_FRAC + 1;
  localparam int RND_HALF  = 1 << (TRIG_FRAC - 1);

  localparam int QTR   = 1 << (ANGLE_BITS - 2);
  localparam int QTR_W = ANGLE_BITS - 1;
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PIX_W = QTR_W + IDX_W;

  localparam int ROT_W  = COORD_WIDTH + 3;
  localparam int PROD_W = ROT_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int D_W    = ((SIZE_W + 2 > ROT_W) ? SIZE_W + 2 : ROT_W) + 2;
  localparam int SP_W   = ROT_W + SIZE_W + 1;
  localparam int NUM_W  = SP_W + 2;
  localparam int DEN_W  = D_W;
  localparam int QS_W   = NUM_W + 2;
  localparam int SUMO_W = QS_W + 1;

  localparam int NB  = NUM_W;
  localparam int NST = 8 + NB + 1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_X  = 0,
    REG_ANGLE_Y  = 1,
    REG_ANGLE_Z  = 2,
    REG_SIZE     = 3,
    REG_OFFSET_X = 4,
    REG_OFFSET_Y = 5
  } reg_idx_e;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SAT    = 2'd1;
  localparam logic [1:0] ST_BEHIND = 2'd2;

  typedef logic [TAB_W-1:0] sin_tab_t [SINE_TABLE_DEPTH+1];

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned tp;
    longint unsigned r;
    longint s;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x  = (HALF_PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      t  = x;
      s  = longint'(x);
      for (int n = 1; n <= 12; n++) begin
        tp = (t * x2) >> 30;
        // taylor term divisor (2n)(2n+1)
        unique case (n)
          1:       t = tp / 64'd6;
          2:       t = tp / 64'd20;
          3:       t = tp / 64'd42;
          4:       t = tp / 64'd72;
          5:       t = tp / 64'd110;
          6:       t = tp / 64'd156;
          7:       t = tp / 64'd210;
          8:       t = tp / 64'd272;
          9:       t = tp / 64'd342;
          10:      t = tp / 64'd420;
          11:      t = tp / 64'd506;
          default: t = tp / 64'd600;
        endcase
        if (n % 2 == 1) begin
          s = s - longint'(t);
        end else begin
          s = s + longint'(t);
        end
      end
      if (s < 0) begin
        s = 0;
      end
      r = (longint'(s) + (64'd1 << 15)) >> 16;
      if (r > (64'd1 << TRIG_FRAC)) begin
        r = 64'd1 << TRIG_FRAC;
      end
      tab[k] = TAB_W'(r);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

// ===== rtl/core/vertex_rotate_project_top.sv =====
// throughput: one word per cycle while no trig refresh or output stall holds the
//   input, set by the fully pipelined multipliers and the one-bit-per-stage
//   divider
// reset: registers take their reset values and the sine/cosine registers are
//   refilled from the table; any angle write repeats that refill
module vertex_rotate_project_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [vrp_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [vrp_pkg::CFG_W-1:0]             cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [vrp_pkg::COORD_WIDTH-1:0] vertex_x_i,
  input  logic signed [vrp_pkg::COORD_WIDTH-1:0] vertex_y_i,
  input  logic signed [vrp_pkg::COORD_WIDTH-1:0] vertex_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [vrp_pkg::COORD_WIDTH-1:0] screen_x_o,
  output logic signed [vrp_pkg::COORD_WIDTH-1:0] screen_y_o,
  output logic [1:0]                            status_o
);
  import vrp_pkg::*;

  localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // configuration
  logic [ANGLE_BITS-1:0]         ang_x_q, ang_y_q, ang_z_q;
  logic [SIZE_W-1:0]             size_q;
  logic signed [COORD_WIDTH-1:0] off_x_q, off_y_q;

  // trig refresh
  logic                     busy_q;
  logic [2:0]               tcnt_q;
  logic                     rd_v_q;
  logic [2:0]               rd_k_q;
  logic                     rd_neg_q;
  logic [TAB_W-1:0]         rom_q;
  logic signed [TRIG_W-1:0] trig_q [6];
  logic [ANGLE_BITS-1:0]    ang_sel, ang_eff;
  logic [1:0]               quad;
  logic [QTR_W-1:0]         phase, u;
  logic [PIX_W-1:0]         scaled, idx_full;
  logic [IDX_W-1:0]         tab_idx;
  logic signed [TRIG_W-1:0] sx, cx, sy, cy, sz, cz;

  // pipeline control
  logic [NST-1:0] v_q;
  logic [NST-1:0] go;
  logic           in_acc;

  // stages
  logic signed [COORD_WIDTH-1:0] s1_vx_q;
  logic signed [PROD_W-1:0]      s1_p0_q, s1_p1_q, s1_p2_q, s1_p3_q;
  logic signed [ROT_W-1:0]       s2_vx_q, s2_y1_q, s2_z1_q;
  logic signed [ROT_W-1:0]       s3_y1_q;
  logic signed [PROD_W-1:0]      s3_p0_q, s3_p1_q, s3_p2_q, s3_p3_q;
  logic signed [ROT_W-1:0]       s4_y1_q, s4_x2_q, s4_z2_q;
  logic signed [PROD_W-1:0]      s5_p0_q, s5_p1_q, s5_p2_q, s5_p3_q;
  logic signed [D_W-1:0]         s5_d_q;
  logic signed [ROT_W-1:0]       s6_x3_q, s6_y3_q;
  logic signed [D_W-1:0]         s6_d_q;
  logic signed [SP_W-1:0]        s7_px_q, s7_py_q;
  logic signed [D_W-1:0]         s7_d_q;
  logic                          s7_beh_q;
  logic [NUM_W-1:0]              s8_nx_q, s8_ny_q;
  logic                          s8_negx_q, s8_negy_q, s8_beh_q;
  logic [DEN_W-1:0]              s8_den_q;

  logic signed [SUM_W-1:0] y1s, z1s, x2s, z2s, x3s, y3s;
  logic signed [D_W-1:0]   d_c;
  logic signed [NUM_W-1:0] nx_c, ny_c;

  // divider
  logic [NUM_W-1:0] dvx_n_q [NB];
  logic [NUM_W-1:0] dvy_n_q [NB];
  logic [DEN_W-1:0] dvx_r_q [NB];
  logic [DEN_W-1:0] dvy_r_q [NB];
  logic [DEN_W-1:0] dv_den_q [NB];
  logic             dv_negx_q [NB];
  logic             dv_negy_q [NB];
  logic             dv_beh_q [NB];
  logic [NUM_W-1:0] dvx_nin [NB];
  logic [NUM_W-1:0] dvy_nin [NB];
  logic [DEN_W-1:0] dvx_rin [NB];
  logic [DEN_W-1:0] dvy_rin [NB];
  logic [DEN_W-1:0] dv_din [NB];
  logic [NUM_W-1:0] dvx_nn [NB];
  logic [NUM_W-1:0] dvy_nn [NB];
  logic [DEN_W-1:0] dvx_rn [NB];
  logic [DEN_W-1:0] dvy_rn [NB];
  logic [DEN_W:0]   shx [NB];
  logic [DEN_W:0]   shy [NB];

  logic signed [QS_W-1:0]   qx, qy, qx_fix, qy_fix;
  logic signed [SUMO_W-1:0] sumx, sumy;
  logic                     satx, saty;
  logic signed [COORD_WIDTH-1:0] fx, fy;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_x_q <= '0;
      ang_y_q <= '0;
      ang_z_q <= '0;
      size_q  <= SIZE_W'(1600);
      off_x_q <= '0;
      off_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ANGLE_X:  ang_x_q <= cfg_wdata_i[ANGLE_BITS-1:0];
        REG_ANGLE_Y:  ang_y_q <= cfg_wdata_i[ANGLE_BITS-1:0];
        REG_ANGLE_Z:  ang_z_q <= cfg_wdata_i[ANGLE_BITS-1:0];
        REG_SIZE:     size_q  <= cfg_wdata_i[SIZE_W-1:0];
        REG_OFFSET_X: off_x_q <= cfg_wdata_i[COORD_WIDTH-1:0];
        REG_OFFSET_Y: off_y_q <= cfg_wdata_i[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // table lookup for the refresh step
  always_comb begin
    unique case (tcnt_q[2:1])
      2'd0:    ang_sel = ang_x_q;
      2'd1:    ang_sel = ang_y_q;
      default: ang_sel = ang_z_q;
    endcase
    ang_eff  = ang_sel + (tcnt_q[0] ? ANGLE_BITS'(QTR) : '0);
    quad     = ang_eff[ANGLE_BITS-1 -: 2];
    phase    = {1'b0, ang_eff[ANGLE_BITS-3:0]};
    u        = quad[0] ? (QTR_W'(QTR) - phase) : phase;
    scaled   = PIX_W'(u) * PIX_W'(SINE_TABLE_DEPTH);
    idx_full = scaled >> (ANGLE_BITS - 2);
    tab_idx  = (idx_full > PIX_W'(SINE_TABLE_DEPTH)) ? IDX_W'(SINE_TABLE_DEPTH)
                                                      : IDX_W'(idx_full);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      tcnt_q <= '0;
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= busy_q;
      if (cfg_we_i && (cfg_idx_i == REG_ANGLE_X || cfg_idx_i == REG_ANGLE_Y ||
                       cfg_idx_i == REG_ANGLE_Z)) begin
        busy_q <= 1'b1;
        tcnt_q <= '0;
      end else if (busy_q) begin
        tcnt_q <= tcnt_q + 3'd1;
        if (tcnt_q == 3'd5) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rom_q    <= SIN_TAB[tab_idx];
    rd_k_q   <= tcnt_q;
    rd_neg_q <= quad[1];
    if (rd_v_q) begin
      trig_q[rd_k_q] <= rd_neg_q ? -$signed(TRIG_W'(rom_q)) : $signed(TRIG_W'(rom_q));
    end
  end

  assign sx = trig_q[0];
  assign cx = trig_q[1];
  assign sy = trig_q[2];
  assign cy = trig_q[3];
  assign sz = trig_q[4];
  assign cz = trig_q[5];

  // pipeline flow: a stage moves when any later stage has room
  for (genvar k = 0; k < NST; k++) begin : g_go
    assign go[k] = !out_stall_i || !(&v_q[NST-1:k]);
  end

  assign in_stall_o  = busy_q || rd_v_q || !go[0];
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (go[0]) begin
        v_q[0] <= in_acc;
      end
      for (int k = 1; k < NST; k++) begin
        if (go[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // rotation and projection arithmetic
  always_comb begin
    y1s  = SUM_W'(s1_p0_q) - SUM_W'(s1_p1_q) + SUM_W'(RND_HALF);
    z1s  = SUM_W'(s1_p2_q) + SUM_W'(s1_p3_q) + SUM_W'(RND_HALF);
    x2s  = SUM_W'(s3_p0_q) + SUM_W'(s3_p1_q) + SUM_W'(RND_HALF);
    z2s  = SUM_W'(s3_p2_q) - SUM_W'(s3_p3_q) + SUM_W'(RND_HALF);
    x3s  = SUM_W'(s5_p0_q) - SUM_W'(s5_p1_q) + SUM_W'(RND_HALF);
    y3s  = SUM_W'(s5_p2_q) + SUM_W'(s5_p3_q) + SUM_W'(RND_HALF);
    d_c  = $signed(D_W'({2'b00, size_q}) * D_W'(3)) - D_W'(s4_z2_q);
    nx_c = (NUM_W'(s7_px_q) <<< 1) + NUM_W'(s7_d_q);
    ny_c = (NUM_W'(s7_py_q) <<< 1) + NUM_W'(s7_d_q);
  end

  always_ff @(posedge clk_i) begin
    if (go[0]) begin
      s1_vx_q <= vertex_x_i;
      s1_p0_q <= PROD_W'(vertex_y_i) * PROD_W'(cx);
      s1_p1_q <= PROD_W'(vertex_z_i) * PROD_W'(sx);
      s1_p2_q <= PROD_W'(vertex_y_i) * PROD_W'(sx);
      s1_p3_q <= PROD_W'(vertex_z_i) * PROD_W'(cx);
    end
    if (go[1]) begin
      s2_vx_q <= ROT_W'(s1_vx_q);
      s2_y1_q <= ROT_W'(y1s >>> TRIG_FRAC);
      s2_z1_q <= ROT_W'(z1s >>> TRIG_FRAC);
    end
    if (go[2]) begin
      s3_y1_q <= s2_y1_q;
      s3_p0_q <= PROD_W'(s2_vx_q) * PROD_W'(cy);
      s3_p1_q <= PROD_W'(s2_z1_q) * PROD_W'(sy);
      s3_p2_q <= PROD_W'(s2_z1_q) * PROD_W'(cy);
      s3_p3_q <= PROD_W'(s2_vx_q) * PROD_W'(sy);
    end
    if (go[3]) begin
      s4_y1_q <= s3_y1_q;
      s4_x2_q <= ROT_W'(x2s >>> TRIG_FRAC);
      s4_z2_q <= ROT_W'(z2s >>> TRIG_FRAC);
    end
    if (go[4]) begin
      s5_p0_q <= PROD_W'(s4_x2_q) * PROD_W'(cz);
      s5_p1_q <= PROD_W'(s4_y1_q) * PROD_W'(sz);
      s5_p2_q <= PROD_W'(s4_x2_q) * PROD_W'(sz);
      s5_p3_q <= PROD_W'(s4_y1_q) * PROD_W'(cz);
      s5_d_q  <= d_c;
    end
    if (go[5]) begin
      s6_x3_q <= ROT_W'(x3s >>> TRIG_FRAC);
      s6_y3_q <= ROT_W'(y3s >>> TRIG_FRAC);
      s6_d_q  <= s5_d_q;
    end
    if (go[6]) begin
      s7_px_q  <= SP_W'(s6_x3_q) * SP_W'($signed({1'b0, size_q}));
      s7_py_q  <= SP_W'(s6_y3_q) * SP_W'($signed({1'b0, size_q}));
      s7_d_q   <= s6_d_q;
      s7_beh_q <= (s6_d_q <= 0);
    end
    if (go[7]) begin
      s8_negx_q <= nx_c[NUM_W-1];
      s8_negy_q <= ny_c[NUM_W-1];
      s8_nx_q   <= nx_c[NUM_W-1] ? NUM_W'(-nx_c) : NUM_W'(nx_c);
      s8_ny_q   <= ny_c[NUM_W-1] ? NUM_W'(-ny_c) : NUM_W'(ny_c);
      s8_den_q  <= DEN_W'(s7_d_q) << 1;
      s8_beh_q  <= s7_beh_q;
    end
  end

  // restoring divider, one quotient bit per stage
  always_comb begin
    dvx_nin[0] = s8_nx_q;
    dvy_nin[0] = s8_ny_q;
    dvx_rin[0] = '0;
    dvy_rin[0] = '0;
    dv_din[0]  = s8_den_q;
    for (int i = 1; i < NB; i++) begin
      dvx_nin[i] = dvx_n_q[i-1];
      dvy_nin[i] = dvy_n_q[i-1];
      dvx_rin[i] = dvx_r_q[i-1];
      dvy_rin[i] = dvy_r_q[i-1];
      dv_din[i]  = dv_den_q[i-1];
    end
    for (int i = 0; i < NB; i++) begin
      shx[i] = {dvx_rin[i], dvx_nin[i][NUM_W-1]};
      shy[i] = {dvy_rin[i], dvy_nin[i][NUM_W-1]};
      if (shx[i] >= {1'b0, dv_din[i]}) begin
        dvx_rn[i] = DEN_W'(shx[i] - {1'b0, dv_din[i]});
        dvx_nn[i] = {dvx_nin[i][NUM_W-2:0], 1'b1};
      end else begin
        dvx_rn[i] = shx[i][DEN_W-1:0];
        dvx_nn[i] = {dvx_nin[i][NUM_W-2:0], 1'b0};
      end
      if (shy[i] >= {1'b0, dv_din[i]}) begin
        dvy_rn[i] = DEN_W'(shy[i] - {1'b0, dv_din[i]});
        dvy_nn[i] = {dvy_nin[i][NUM_W-2:0], 1'b1};
      end else begin
        dvy_rn[i] = shy[i][DEN_W-1:0];
        dvy_nn[i] = {dvy_nin[i][NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NB; i++) begin
      if (go[8+i]) begin
        dvx_n_q[i]  <= dvx_nn[i];
        dvy_n_q[i]  <= dvy_nn[i];
        dvx_r_q[i]  <= dvx_rn[i];
        dvy_r_q[i]  <= dvy_rn[i];
        dv_den_q[i] <= dv_din[i];
        if (i == 0) begin
          dv_negx_q[i] <= s8_negx_q;
          dv_negy_q[i] <= s8_negy_q;
          dv_beh_q[i]  <= s8_beh_q;
        end else begin
          dv_negx_q[i] <= dv_negx_q[i-1];
          dv_negy_q[i] <= dv_negy_q[i-1];
          dv_beh_q[i]  <= dv_beh_q[i-1];
        end
      end
    end
  end

  // floor correction, offset and saturation
  always_comb begin
    qx     = $signed({2'b00, dvx_n_q[NB-1]});
    qy     = $signed({2'b00, dvy_n_q[NB-1]});
    qx_fix = dv_negx_q[NB-1] ? (-qx - QS_W'(dvx_r_q[NB-1] != '0)) : qx;
    qy_fix = dv_negy_q[NB-1] ? (-qy - QS_W'(dvy_r_q[NB-1] != '0)) : qy;
    sumx   = SUMO_W'(off_x_q) + SUMO_W'(qx_fix);
    sumy   = SUMO_W'(off_y_q) + SUMO_W'(qy_fix);
    satx   = (sumx > SUMO_W'(CMAX)) || (sumx < SUMO_W'(CMIN));
    saty   = (sumy > SUMO_W'(CMAX)) || (sumy < SUMO_W'(CMIN));
    if (sumx > SUMO_W'(CMAX)) begin
      fx = CMAX;
    end else if (sumx < SUMO_W'(CMIN)) begin
      fx = CMIN;
    end else begin
      fx = COORD_WIDTH'(sumx);
    end
    if (sumy > SUMO_W'(CMAX)) begin
      fy = CMAX;
    end else if (sumy < SUMO_W'(CMIN)) begin
      fy = CMIN;
    end else begin
      fy = COORD_WIDTH'(sumy);
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[NST-1]) begin
      if (dv_beh_q[NB-1]) begin
        screen_x_o <= '0;
        screen_y_o <= '0;
        status_o   <= ST_BEHIND;
      end else begin
        screen_x_o <= fx;
        screen_y_o <= fy;
        status_o   <= (satx || saty) ? ST_SAT : ST_OK;
      end
    end
  end

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> in_stall_o)
    else $error("input taken during trig refresh");

  a_angle_refresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == REG_ANGLE_X || cfg_idx_i == REG_ANGLE_Y ||
                 cfg_idx_i == REG_ANGLE_Z) |=> busy_q)
    else $error("angle write did not start refresh");

  a_behind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_BEHIND |-> screen_x_o == '0 && screen_y_o == '0)
    else $error("behind-plane word has nonzero coordinates");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_SAT || status_o == ST_BEHIND)
    else $error("bad status code");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vrp_pkg::*;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] sx;
    logic signed [COORD_WIDTH-1:0] sy;
    logic [1:0]                    st;
  } screen_pt_t;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] vx;
    logic signed [COORD_WIDTH-1:0] vy;
    logic signed [COORD_WIDTH-1:0] vz;
    bit                            typed;
    screen_pt_t                    want;
  } vertex_row_t;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int N_ROWS = 16;
  localparam int CYCLE_LIMIT = 300000;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic in_valid_i, in_stall_o;
  logic signed [COORD_WIDTH-1:0] vertex_x_i, vertex_y_i, vertex_z_i;
  logic out_valid_o, out_stall_i;
  logic signed [COORD_WIDTH-1:0] screen_x_o, screen_y_o;
  logic [1:0] status_o;

  vertex_rotate_project_top dut (.*);

  longint sine_q14 [SINE_TABLE_DEPTH+1];
  int unsigned ang_x, ang_y, ang_z;
  longint size_q4, ofs_x, ofs_y;
  screen_pt_t pending_pts[$];
  vertex_row_t rows [N_ROWS];
  int idle_pct, stall_pct;
  int mismatches;
  int cycles;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  function automatic void fill_sine();
    longint unsigned x, x2, t;
    longint s, r;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x  = (HALF_PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      t  = x;
      s  = longint'(x);
      for (int n = 1; n <= 12; n++) begin
        t = ((t * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        s = (n % 2 == 1) ? s - longint'(t) : s + longint'(t);
      end
      if (s < 0) s = 0;
      r = (s + (64'd1 << 15)) >>> 16;
      sine_q14[k] = (r > (1 << TRIG_FRAC)) ? (1 << TRIG_FRAC) : r;
    end
  endfunction

  function automatic longint trig(int unsigned a, bit want_cos);
    int unsigned full, quad, p, u, idx;
    longint mag;
    full = (1 << ANGLE_BITS) - 1;
    a = a & full;
    if (want_cos) a = (a + QTR) & full;
    quad = a >> (ANGLE_BITS - 2);
    p = a & (QTR - 1);
    u = (quad % 2 == 0) ? p : QTR - p;
    idx = 32'((longint'(u) * SINE_TABLE_DEPTH) / QTR);
    if (idx > SINE_TABLE_DEPTH) idx = SINE_TABLE_DEPTH;
    mag = sine_q14[idx];
    return (quad >= 2) ? -mag : mag;
  endfunction

  function automatic longint rnd_q14(longint v);
    return floor_div(v + RND_HALF, 1 << TRIG_FRAC);
  endfunction

  function automatic screen_pt_t project_vertex(longint vx, longint vy, longint vz);
    longint cx, snx, cy, sny, cz, snz, y1, z1, x2, z2, x3, y3, d, px, py, hi, lo;
    bit clamped;
    screen_pt_t r;
    hi = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    lo = -hi - 1;
    clamped = 1'b0;
    cx = trig(ang_x, 1'b1); snx = trig(ang_x, 1'b0);
    cy = trig(ang_y, 1'b1); sny = trig(ang_y, 1'b0);
    cz = trig(ang_z, 1'b1); snz = trig(ang_z, 1'b0);
    y1 = rnd_q14(vy * cx - vz * snx);
    z1 = rnd_q14(vy * snx + vz * cx);
    x2 = rnd_q14(vx * cy + z1 * sny);
    z2 = rnd_q14(z1 * cy - vx * sny);
    x3 = rnd_q14(x2 * cz - y1 * snz);
    y3 = rnd_q14(x2 * snz + y1 * cz);
    d = 3 * size_q4 - z2;
    if (d <= 0) begin
      r.sx = '0;
      r.sy = '0;
      r.st = ST_BEHIND;
      return r;
    end
    px = ofs_x + floor_div(2 * x3 * size_q4 + d, 2 * d);
    py = ofs_y + floor_div(2 * y3 * size_q4 + d, 2 * d);
    if (px > hi) begin px = hi; clamped = 1'b1; end
    if (px < lo) begin px = lo; clamped = 1'b1; end
    if (py > hi) begin py = hi; clamped = 1'b1; end
    if (py < lo) begin py = lo; clamped = 1'b1; end
    r.sx = px[COORD_WIDTH-1:0];
    r.sy = py[COORD_WIDTH-1:0];
    r.st = clamped ? ST_SAT : ST_OK;
    return r;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
    case ($urandom_range(3))
      0: return COORD_WIDTH'($urandom);
      1: return COORD_WIDTH'($urandom_range(2000) - 1000);
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return COORD_WIDTH'($urandom_range(16000) - 8000);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_ANGLE_X:  ang_x = 32'(data[ANGLE_BITS-1:0]);
      REG_ANGLE_Y:  ang_y = 32'(data[ANGLE_BITS-1:0]);
      REG_ANGLE_Z:  ang_z = 32'(data[ANGLE_BITS-1:0]);
      REG_SIZE:     size_q4 = longint'(data[SIZE_W-1:0]);
      REG_OFFSET_X: ofs_x = longint'($signed(data[COORD_WIDTH-1:0]));
      REG_OFFSET_Y: ofs_y = longint'($signed(data[COORD_WIDTH-1:0]));
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_vertex(input vertex_row_t row);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vertex_x_i <= row.vx;
    vertex_y_i <= row.vy;
    vertex_z_i <= row.vz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_pts.insert(pending_pts.size(),
                       row.typed ? row.want : project_vertex(row.vx, row.vy, row.vz));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    screen_pt_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word x=%0d y=%0d st=%0d",
                                       screen_x_o, screen_y_o, status_o);
      end else begin
        e = pending_pts.pop_front();
        if (e.sx !== screen_x_o || e.sy !== screen_y_o || e.st !== status_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d st=%0d, got x=%0d y=%0d st=%0d",
                     e.sx, e.sy, e.st, screen_x_o, screen_y_o, status_o);
        end
      end
    end
  end

  initial begin
    vertex_row_t row;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    vertex_x_i = '0;
    vertex_y_i = '0;
    vertex_z_i = '0;
    out_stall_i = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    cycles = 0;
    ang_x = 0; ang_y = 0; ang_z = 0;
    size_q4 = 1600; ofs_x = 0; ofs_y = 0;
    fill_sine();

    rows[0]  = '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, ST_OK}};
    rows[1]  = '{16'sd0, 16'sd0, 16'sd4800, 1'b1, '{16'sd0, 16'sd0, ST_BEHIND}};
    rows[2]  = '{16'sd100, 16'sd200, 16'sh7fff, 1'b1, '{16'sd0, 16'sd0, ST_BEHIND}};
    rows[3]  = '{16'sh7fff, 16'sd0, 16'sd4799, 1'b1, '{16'sh7fff, 16'sd0, ST_SAT}};
    rows[4]  = '{16'sh8000, 16'sd0, 16'sd4799, 1'b1, '{16'sh8000, 16'sd0, ST_SAT}};
    rows[5]  = '{16'sd0, 16'sh7fff, 16'sd4799, 1'b1, '{16'sd0, 16'sh7fff, ST_SAT}};
    rows[6]  = '{16'sd0, 16'sh8000, 16'sd4799, 1'b1, '{16'sd0, 16'sh8000, ST_SAT}};
    rows[7]  = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, '{16'sd0, 16'sd0, ST_OK}};
    rows[8]  = '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '{16'sd0, 16'sd0, ST_OK}};
    rows[9]  = '{16'sh7fff, 16'sh8000, 16'sd0, 1'b0, '{16'sd0, 16'sd0, ST_OK}};
    rows[10] = '{16'sd16, -16'sd16, 16'sd16, 1'b0, '{16'sd0, 16'sd0, ST_OK}};
    rows[11] = '{16'sd1, 16'sd1, -16'sd1, 1'b0, '{16'sd0, 16'sd0, ST_OK}};
    rows[12] = '{-16'sd1000, 16'sd700, 16'sd4000, 1'b0, '{16'sd0, 16'sd0, ST_OK}};
    rows[13] = '{16'sd8000, -16'sd8000, 16'sd4798, 1'b0, '{16'sd0, 16'sd0, ST_OK}};
    rows[14] = '{16'sd300, 16'sd300, 16'sh8000, 1'b0, '{16'sd0, 16'sd0, ST_OK}};
    rows[15] = '{16'sd5555, 16'sd1234, 16'sd4801, 1'b1, '{16'sd0, 16'sd0, ST_BEHIND}};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_ROWS; i++) send_vertex(rows[i]);
    drain();

    for (int ph = 1; ph <= 8; ph++) begin
      case (ph)
        1: begin
          write_reg(REG_ANGLE_X, 16'h0000); write_reg(REG_ANGLE_Y, 16'h0000);
          write_reg(REG_ANGLE_Z, 16'h0000); write_reg(REG_SIZE, 16'd16);
          write_reg(REG_OFFSET_X, 16'h7fff); write_reg(REG_OFFSET_Y, 16'h7fff);
        end
        2: begin
          write_reg(REG_ANGLE_X, 16'hffff); write_reg(REG_ANGLE_Y, 16'h0fff);
          write_reg(REG_ANGLE_Z, 16'hffff); write_reg(REG_SIZE, 16'hffff);
          write_reg(REG_OFFSET_X, 16'h8000); write_reg(REG_OFFSET_Y, 16'h8000);
          write_reg(REG_SPARE_A, CFG_W'($urandom));
          write_reg(REG_SPARE_B, CFG_W'($urandom));
        end
        3: begin
          write_reg(REG_ANGLE_X, 16'd1024); write_reg(REG_ANGLE_Y, 16'd2048);
          write_reg(REG_ANGLE_Z, 16'd3072); write_reg(REG_SIZE, 16'd0);
        end
        default: begin
          write_reg(REG_ANGLE_X, CFG_W'($urandom));
          write_reg(REG_ANGLE_Y, CFG_W'($urandom));
          write_reg(REG_ANGLE_Z, CFG_W'($urandom));
          write_reg(REG_SIZE, $urandom_range(1) ? CFG_W'($urandom_range(16, 8000))
                                                : CFG_W'($urandom));
          write_reg(REG_OFFSET_X, CFG_W'($urandom));
          write_reg(REG_OFFSET_Y, CFG_W'($urandom));
        end
      endcase
      cfg_we_i <= 1'b0;
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      for (int i = 0; i < 50; i++) begin
        row.vx = rand_coord();
        row.vy = rand_coord();
        row.vz = rand_coord();
        row.typed = 1'b0;
        send_vertex(row);
      end
      drain();
    end

    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
